// ===== rtl/core/ice_pkg.sv =====
// Package for the infix calculator evaluator: operator codes, error codes,
// sequencer states and character constants. No dependencies.
package ice_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_MUL   = 2'd1,
        OP_DIV   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_OVF   = 2'd2,
        ERR_LIMIT = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

endpackage

// ===== rtl/core/ice_muldiv.sv =====
// Shared shift-add multiplier / restoring divider, one bit per cycle.
// No dependencies.
module ice_muldiv
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_div,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [63:0] quo,
    output logic        ovf
);

    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;     // product or quotient
    logic [63:0] sh_reg, sh_next;       // multiplicand or dividend bits
    logic [32:0] rem_reg, rem_next;
    logic [31:0] b_reg, b_next;
    logic        ovf_reg, ovf_next;
    logic [64:0] sum;
    logic [32:0] trial;
    logic [32:0] rsh;

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        b_next    = b_reg;
        ovf_next  = ovf_reg;
        done      = 1'b0;
        sum       = {1'b0, acc_reg} + {1'b0, sh_reg};
        rsh       = {rem_reg[31:0], sh_reg[63]};
        trial     = rsh - {1'b0, b_reg};
        if (start)
        begin
            busy_next = 1'b1;
            div_next  = is_div;
            cnt_next  = is_div ? 6'd63 : 6'd31;
            acc_next  = '0;
            sh_next   = a;
            rem_next  = '0;
            b_next    = b;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // restoring step: shift in next dividend bit
                sh_next = {sh_reg[62:0], 1'b0};
                if (!trial[32])
                begin
                    rem_next = trial;
                    acc_next = {acc_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    acc_next = {acc_reg[62:0], 1'b0};
                end
            end
            else
            begin
                // multiplier bit from LSB; shift multiplicand left
                if (b_reg[0])
                begin
                    acc_next = sum[63:0];
                    if (sum[64] || sum[63] || (sh_reg[63]))
                        ovf_next = 1'b1;
                end
                b_next = {1'b0, b_reg[31:1]};
                if (sh_reg[63] && (b_reg[31:1] != '0))
                    ovf_next = 1'b1;
                sh_next = {sh_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quo = acc_next;
    assign ovf = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
        ovf_reg <= ovf_next;
    end

endmodule

// ===== rtl/core/infix_calculator_evaluator.sv =====
// Infix calculator evaluator: one ASCII character per item, result at NUL.
// A digit or an ignored character is accepted without leaving ST_IDLE. An
// operator that closes a multiply or a divide goes through ST_MUL or ST_DIV,
// waiting on the shared one-bit-per-cycle multiply/divide unit; every operand is finished in ST_ADD.
// Results are signed fixed point with FRAC_BITS fraction bits, saturated on
// overflow. Depends on ice_pkg and ice_muldiv.
module infix_calculator_evaluator
#(
    parameter int MAX_CHARS    = 20,
    parameter int MAX_OPERANDS = 8,
    parameter int FRAC_BITS    = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] result_value,
    output logic [1:0]         error_code
);

    ice_pkg::state_t state_reg, state_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] term_reg, term_next;
    logic        neg_reg, neg_next;
    logic [31:0] num_reg, num_next;
    ice_pkg::op_t op_reg, op_next;
    logic        amd_reg, amd_next;
    logic [4:0]  cc_reg, cc_next;
    logic [3:0]  oc_reg, oc_next;
    ice_pkg::err_t err_reg, err_next;
    logic [7:0]  ch_reg, ch_next;        // operator that caused the close
    logic [63:0] res_reg, res_next;
    logic [1:0]  rerr_reg, rerr_next;
    logic        ov_reg, ov_next;

    logic        md_start, md_div, md_done, md_ovf;
    logic [63:0] md_quo;
    logic        acc;
    logic [35:0] digit_v;
    logic [63:0] addend, addsum;
    logic        add_ovf;
    logic [63:0] sat_neg, sat_pos;

    ice_muldiv u_md
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (md_div),
        .a      (term_reg),
        .b      (num_reg),
        .done   (md_done),
        .quo    (md_quo),
        .ovf    (md_ovf)
    );

    assign in_stall     = (state_reg != ice_pkg::ST_IDLE);
    assign acc          = in_valid && !in_stall;
    assign out_valid    = ov_reg;
    assign result_value = res_reg;
    assign error_code   = rerr_reg;

    assign sat_neg = ice_pkg::NEG_MIN;
    assign sat_pos = ice_pkg::MAG_MAX;
    assign addend  = neg_reg ? (~term_reg + 64'd1) : term_reg;
    assign addsum  = sum_reg + addend;
    assign add_ovf = (sum_reg[63] == addend[63]) && (addsum[63] != sum_reg[63]);
    assign digit_v = ({4'd0, num_reg} << 3) + ({4'd0, num_reg} << 1)
                   + {28'd0, char_code - ice_pkg::CH_ZERO};

    always_comb
    begin
        state_next = state_reg;
        sum_next = sum_reg; term_next = term_reg; neg_next = neg_reg;
        num_next = num_reg; op_next = op_reg; amd_next = amd_reg;
        cc_next = cc_reg; oc_next = oc_reg; err_next = err_reg;
        ch_next = ch_reg; res_next = res_reg; rerr_next = rerr_reg;
        ov_next = ov_reg;
        md_start = 1'b0;
        md_div   = (op_reg == ice_pkg::OP_DIV);
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ice_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (char_code == ice_pkg::CH_NUL)
                    begin
                        ch_next = char_code;
                        if (err_reg != ice_pkg::ERR_NONE)
                            state_next = ice_pkg::ST_OUT;
                        else if (oc_reg >= 4'(MAX_OPERANDS))
                        begin
                            err_next = ice_pkg::ERR_LIMIT;
                            state_next = ice_pkg::ST_OUT;
                        end
                        else
                        begin
                            oc_next = oc_reg + 4'd1;
                            case (op_reg)
                                ice_pkg::OP_MUL:
                                begin
                                    md_start = 1'b1;
                                    state_next = ice_pkg::ST_MUL;
                                end
                                ice_pkg::OP_DIV:
                                begin
                                    if (num_reg == '0)
                                    begin
                                        err_next = ice_pkg::ERR_DIV0;
                                        state_next = ice_pkg::ST_OUT;
                                    end
                                    else
                                    begin
                                        md_start = 1'b1;
                                        state_next = ice_pkg::ST_DIV;
                                    end
                                end
                                default:
                                begin
                                    term_next = 64'({32'd0, num_reg}) << FRAC_BITS;
                                    num_next = '0;
                                    state_next = ice_pkg::ST_ADD;
                                end
                            endcase
                        end
                    end
                    else if (err_reg != ice_pkg::ERR_NONE)
                    begin
                        // drop characters after an error
                    end
                    else if (cc_reg >= 5'(MAX_CHARS - 1))
                        err_next = ice_pkg::ERR_LIMIT;
                    else
                    begin
                        cc_next = cc_reg + 5'd1;
                        amd_next = 1'b0;
                        if (amd_reg && char_code == ice_pkg::CH_MINUS)
                            neg_next = !neg_reg;
                        else if (char_code >= ice_pkg::CH_ZERO
                                 && char_code <= ice_pkg::CH_NINE)
                        begin
                            if (digit_v[35:32] != '0)
                            begin
                                err_next = ice_pkg::ERR_OVF;
                                sum_next = neg_reg ? sat_neg : sat_pos;
                            end
                            else
                                num_next = digit_v[31:0];
                        end
                        else
                        begin
                            ch_next = char_code;
                            if (oc_reg >= 4'(MAX_OPERANDS))
                                err_next = ice_pkg::ERR_LIMIT;
                            else
                            begin
                                oc_next = oc_reg + 4'd1;
                                case (op_reg)
                                    ice_pkg::OP_MUL:
                                    begin
                                        md_start = 1'b1;
                                        state_next = ice_pkg::ST_MUL;
                                    end
                                    ice_pkg::OP_DIV:
                                    begin
                                        if (num_reg == '0)
                                            err_next = ice_pkg::ERR_DIV0;
                                        else
                                        begin
                                            md_start = 1'b1;
                                            state_next = ice_pkg::ST_DIV;
                                        end
                                    end
                                    default:
                                    begin
                                        term_next = 64'({32'd0, num_reg})
                                                    << FRAC_BITS;
                                        num_next = '0;
                                        state_next = ice_pkg::ST_ADD;
                                    end
                                endcase
                            end
                        end
                    end
                end
            end
            ice_pkg::ST_MUL, ice_pkg::ST_DIV:
            begin
                if (md_done)
                begin
                    if (state_reg == ice_pkg::ST_MUL && md_ovf && num_reg != '0)
                    begin
                        err_next = ice_pkg::ERR_OVF;
                        sum_next = neg_reg ? sat_neg : sat_pos;
                        state_next = (ch_reg == ice_pkg::CH_NUL)
                                     ? ice_pkg::ST_OUT : ice_pkg::ST_IDLE;
                    end
                    else
                    begin
                        term_next = md_quo;
                        num_next = '0;
                        state_next = ice_pkg::ST_ADD;
                    end
                end
            end
            ice_pkg::ST_ADD:
            begin
                // finish the operand: add term or set up the next op
                if (ch_reg == ice_pkg::CH_NUL || ch_reg == ice_pkg::CH_PLUS
                    || ch_reg == ice_pkg::CH_MINUS)
                begin
                    if (add_ovf)
                    begin
                        err_next = ice_pkg::ERR_OVF;
                        sum_next = sum_reg[63] ? sat_neg : sat_pos;
                    end
                    else
                    begin
                        sum_next = addsum;
                        neg_next = (ch_reg == ice_pkg::CH_MINUS);
                        term_next = '0;
                        op_next = ice_pkg::OP_START;
                    end
                end
                else
                begin
                    op_next = (ch_reg == ice_pkg::CH_STAR)
                              ? ice_pkg::OP_MUL : ice_pkg::OP_DIV;
                    amd_next = 1'b1;
                end
                state_next = (ch_reg == ice_pkg::CH_NUL)
                             ? ice_pkg::ST_OUT : ice_pkg::ST_IDLE;
            end
            ice_pkg::ST_OUT:
            begin
                if (!ov_reg)
                begin
                    res_next = (err_reg == ice_pkg::ERR_NONE
                                || err_reg == ice_pkg::ERR_OVF) ? sum_reg : '0;
                    rerr_next = err_reg;
                    ov_next = 1'b1;
                    sum_next = '0; term_next = '0; neg_next = 1'b0;
                    num_next = '0; op_next = ice_pkg::OP_START;
                    amd_next = 1'b0; cc_next = '0; oc_next = '0;
                    err_next = ice_pkg::ERR_NONE;
                    state_next = ice_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ice_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ice_pkg::ST_IDLE;
            sum_reg <= '0; term_reg <= '0; neg_reg <= 1'b0;
            num_reg <= '0; op_reg <= ice_pkg::OP_START; amd_reg <= 1'b0;
            cc_reg <= '0; oc_reg <= '0; err_reg <= ice_pkg::ERR_NONE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg <= sum_next; term_reg <= term_next; neg_reg <= neg_next;
            num_reg <= num_next; op_reg <= op_next; amd_reg <= amd_next;
            cc_reg <= cc_next; oc_reg <= oc_next; err_reg <= err_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        res_reg  <= res_next;
        rerr_reg <= rerr_next;
    end

endmodule
